[hw/rtl/smt_pkg.sv]
// Shared constants and types for the set membership table.
package smt_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;

	// Port key width is fixed; only its low STORE_W bits take part.
	localparam int IN_KEY_W = 32;
	localparam int STORE_W  = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/set_membership_table.sv]
// A request passes through a scan that reads one key store entry per cycle, then a
// compare drain and a commit; the commit waits while the output register is still full.
// A new request is taken only once the previous one has committed.
// A new request is taken while the previous result still waits in the output register.
// Reset clears all valid marks, the entry count and the control state at once;
// the key store itself is not cleared.
module set_membership_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [smt_pkg::IN_KEY_W-1:0] key,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         was_present,
	output logic [smt_pkg::CNT_W-1:0]    entry_count,
	output logic                         full_refused
);

	smt_pkg::cmd_t    cmd;
	smt_pkg::status_t status;

	smt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	smt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.key          (key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_present  (was_present),
		.entry_count  (entry_count),
		.full_refused (full_refused)
	);

endmodule

[hw/rtl/smt_ctrl.sv]
// Controller state machine sequencing the scan and commit of one request.
module smt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smt_pkg::status_t status,
	output smt_pkg::cmd_t    cmd
);

	smt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smt_pkg::ST_IDLE: begin
				if (in_valid) state_d = smt_pkg::ST_SCAN;
			end
			smt_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = smt_pkg::ST_DRAIN;
			end
			smt_pkg::ST_DRAIN: begin
				state_d = smt_pkg::ST_COMMIT;
			end
			smt_pkg::ST_COMMIT: begin
				if (status.out_free) state_d = smt_pkg::ST_IDLE;
			end
			default: begin
				state_d = smt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			smt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			smt_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			smt_pkg::ST_DRAIN: begin
			end
			smt_pkg::ST_COMMIT: begin
				// The table changes in the same cycle the result is registered.
				cmd.commit = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/smt_datapath.sv]
// Datapath: key store, valid marks, entry count, scan tracking and result register.
module smt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smt_pkg::cmd_t                     cmd,
	output smt_pkg::status_t                  status,
	input  logic [1:0]                        mode,
	input  logic [smt_pkg::IN_KEY_W-1:0]      key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              was_present,
	output logic [smt_pkg::CNT_W-1:0]         entry_count,
	output logic                              full_refused
);

	logic [smt_pkg::STORE_W-1:0]  mem [smt_pkg::CAPACITY];
	logic [smt_pkg::STORE_W-1:0]  rd_s1;
	logic [smt_pkg::IDX_W-1:0]    idx_s1;
	logic                         cmp_s1;

	logic [smt_pkg::STORE_W-1:0]  key_q;
	logic [1:0]                   mode_q;
	logic [smt_pkg::IDX_W-1:0]    idx_q;
	logic                         hit_q;
	logic [smt_pkg::IDX_W-1:0]    hit_idx_q;
	logic                         free_found_q;
	logic [smt_pkg::IDX_W-1:0]    free_idx_q;
	logic [smt_pkg::CAPACITY-1:0] valid_q;
	logic [smt_pkg::CNT_W-1:0]    count_q;
	logic                         out_valid_q;

	logic                         do_insert;
	logic                         do_remove;
	logic                         refuse;
	logic [smt_pkg::CNT_W-1:0]    count_d;

	assign status.scan_last = (idx_q == smt_pkg::IDX_W'(smt_pkg::CAPACITY - 1));
	assign status.out_free  = !out_valid_q || out_ready;

	// Key store: written only at commit, read one entry per scan cycle.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			mem[free_idx_q] <= key_q;
		end
		if (cmd.scan) begin
			rd_s1 <= mem[idx_q];
		end
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key[smt_pkg::STORE_W-1:0];
			mode_q <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cmp_s1       <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			cmp_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q        <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan && !status.scan_last) begin
					idx_q <= idx_q + smt_pkg::IDX_W'(1);
				end
				if (cmp_s1) begin
					if (valid_q[idx_s1] && (rd_s1 == key_q)) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					// Keep the lowest numbered free entry.
					if (!valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
				end
			end
		end
	end

	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		refuse    = 1'b0;
		count_d   = count_q;
		if (mode_q == smt_pkg::MODE_INSERT && !hit_q) begin
			if (free_found_q && (count_q < smt_pkg::CNT_W'(smt_pkg::CAPACITY))) begin
				do_insert = 1'b1;
				count_d   = count_q + smt_pkg::CNT_W'(1);
			end else begin
				refuse = 1'b1;
			end
		end else if (mode_q == smt_pkg::MODE_REMOVE && hit_q) begin
			do_remove = 1'b1;
			if (count_q != '0) begin
				count_d = count_q - smt_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
				if (do_insert) valid_q[free_idx_q] <= 1'b1;
				if (do_remove) valid_q[hit_idx_q]  <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_present  <= hit_q;
			entry_count  <= count_d;
			full_refused <= refuse;
		end
	end

	assign out_valid = out_valid_q;

endmodule
